// ----- rtl/lpip_pkg.sv -----
package lpip_pkg;

    // Field widths
    localparam int COORD_WIDTH = 32;
    localparam int PIXEL_WIDTH = 12;
    localparam int COEF_WIDTH  = 32;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 3;

    // Datapath widths
    localparam int PROD_W = COEF_WIDTH + COORD_WIDTH;
    localparam int SUM_W  = PROD_W + 2;
    localparam int REM_W  = SUM_W + PIXEL_WIDTH;
    localparam int SQ_W   = 2 * COORD_WIDTH + 2;
    localparam int FRAC_W = 16;

    // Squared range limit: 1.0 in Q32.32
    localparam logic [SQ_W-1:0] ONE_SQ = SQ_W'(1) << 32;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_ROW0_A  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW0_B  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW1_A  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW1_B  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW2_A  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW2_B  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_WIDTH   = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT  = 3'd7;

    localparam logic [PIXEL_WIDTH-1:0] WIDTH_RST  = PIXEL_WIDTH'(1920);
    localparam logic [PIXEL_WIDTH-1:0] HEIGHT_RST = PIXEL_WIDTH'(1208);

    // Status codes
    localparam logic [1:0] ST_ON_IMAGE  = 2'd0;
    localparam logic [1:0] ST_BEHIND    = 2'd1;
    localparam logic [1:0] ST_TOO_CLOSE = 2'd2;
    localparam logic [1:0] ST_OFF_IMAGE = 2'd3;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] point_x;
        logic signed [COORD_WIDTH-1:0] point_y;
        logic signed [COORD_WIDTH-1:0] point_z;
    } point_t;

    typedef struct packed {
        logic [PIXEL_WIDTH-1:0] pixel_u;
        logic [PIXEL_WIDTH-1:0] pixel_v;
        logic [1:0]             status;
    } pixel_t;

    typedef logic [2:0][3:0][COEF_WIDTH-1:0] matrix_t;

    // Word handed along the divider chain
    typedef struct packed {
        logic [1:0]             status;
        logic                   sign_u;
        logic                   sign_v;
        logic                   sign_d;
        logic [SUM_W-1:0]       dm;
        logic [REM_W-1:0]       rem_u;
        logic [REM_W-1:0]       rem_v;
        logic [PIXEL_WIDTH-1:0] q_u;
        logic [PIXEL_WIDTH-1:0] q_v;
    } div_t;

endpackage

// ----- rtl/lpip_front.sv -----
module lpip_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  lpip_pkg::point_t in_word,
    input  lpip_pkg::matrix_t coef,
    output logic             out_valid,
    input  logic             out_ready,
    output lpip_pkg::div_t   out_word
);
    import lpip_pkg::*;

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic s1_ready, s2_ready, s3_ready, s4_ready, s5_ready;

    // Stage 1: products and squares
    logic signed [PROD_W-1:0]    prod_next [3][3];
    logic signed [PROD_W-1:0]    s1_prod_reg [3][3];
    logic [2*COORD_WIDTH-1:0]    sq_next [3];
    logic [2*COORD_WIDTH-1:0]    s1_sq_reg [3];
    logic                        behind_next, s1_behind_reg;
    // Stage 2: pair sums
    logic signed [SUM_W-1:0]     pa_next [3], pb_next [3];
    logic signed [SUM_W-1:0]     s2_pa_reg [3], s2_pb_reg [3];
    logic [SQ_W-1:0]             s2_sq01_reg, s2_sq2_reg;
    logic                        s2_behind_reg;
    // Stage 3: row values and range test
    logic signed [SUM_W-1:0]     n_next [3], s3_n_reg [3];
    logic [SQ_W-1:0]             sqsum;
    logic [1:0]                  s3_status_next, s3_status_reg;
    // Stage 4: magnitudes
    logic [SUM_W-1:0]            mag_next [3], s4_mag_reg [3];
    logic [2:0]                  s4_sign_reg;
    logic [1:0]                  s4_status_next, s4_status_reg;
    // Stage 5: overflow test and divider setup
    logic [REM_W-1:0]            dsh;
    logic                        over;
    lpip_pkg::div_t              s5_word_next, s5_word_reg;

    assign s5_ready = !s5_valid_reg || out_ready;
    assign s4_ready = !s4_valid_reg || s5_ready;
    assign s3_ready = !s3_valid_reg || s4_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    // Multiply each coordinate by its coefficient, square the coordinates, flag points behind
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            prod_next[r][0] = $signed(coef[r][0]) * in_word.point_x;
            prod_next[r][1] = $signed(coef[r][1]) * in_word.point_y;
            prod_next[r][2] = $signed(coef[r][2]) * in_word.point_z;
        end
        sq_next[0] = $signed(in_word.point_x) * $signed(in_word.point_x);
        sq_next[1] = $signed(in_word.point_y) * $signed(in_word.point_y);
        sq_next[2] = $signed(in_word.point_z) * $signed(in_word.point_z);
        behind_next = !(in_word.point_y > 0 ||
                        (in_word.point_x == '0 && in_word.point_y == '0));
    end

    // Add in pairs; offset moves to Q32.32
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            pa_next[r] = SUM_W'(s1_prod_reg[r][0]) + SUM_W'(s1_prod_reg[r][1]);
            pb_next[r] = SUM_W'(s1_prod_reg[r][2])
                       + SUM_W'($signed({coef[r][3], {FRAC_W{1'b0}}}));
        end
    end

    // Finish the row sums and classify early failures
    always_comb
    begin
        for (int r = 0; r < 3; r++)
            n_next[r] = s2_pa_reg[r] + s2_pb_reg[r];
        sqsum = s2_sq01_reg + s2_sq2_reg;
        if (s2_behind_reg)
            s3_status_next = ST_BEHIND;
        else if (sqsum < ONE_SQ)
            s3_status_next = ST_TOO_CLOSE;
        else
            s3_status_next = ST_ON_IMAGE;
    end

    // Split into sign and magnitude, flag zero depth
    always_comb
    begin
        for (int r = 0; r < 3; r++)
            mag_next[r] = s3_n_reg[r][SUM_W-1] ? SUM_W'(-s3_n_reg[r]) : SUM_W'(s3_n_reg[r]);
        if (s3_status_reg == ST_ON_IMAGE && s3_n_reg[2] == '0)
            s4_status_next = ST_OFF_IMAGE;
        else
            s4_status_next = s3_status_reg;
    end

    // Drop quotients that cannot fit the pixel width
    always_comb
    begin
        dsh  = REM_W'(s4_mag_reg[2]) << PIXEL_WIDTH;
        over = (REM_W'(s4_mag_reg[0]) >= dsh) || (REM_W'(s4_mag_reg[1]) >= dsh);
        s5_word_next.status = (s4_status_reg == ST_ON_IMAGE && over) ? ST_OFF_IMAGE
                                                                      : s4_status_reg;
        s5_word_next.sign_u = s4_sign_reg[0];
        s5_word_next.sign_v = s4_sign_reg[1];
        s5_word_next.sign_d = s4_sign_reg[2];
        s5_word_next.dm     = s4_mag_reg[2];
        s5_word_next.rem_u  = REM_W'(s4_mag_reg[0]);
        s5_word_next.rem_v  = REM_W'(s4_mag_reg[1]);
        s5_word_next.q_u    = '0;
        s5_word_next.q_v    = '0;
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready) s1_valid_reg <= in_valid;
            if (s2_ready) s2_valid_reg <= s1_valid_reg;
            if (s3_ready) s3_valid_reg <= s2_valid_reg;
            if (s4_ready) s4_valid_reg <= s3_valid_reg;
            if (s5_ready) s5_valid_reg <= s4_valid_reg;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_prod_reg   <= prod_next;
            s1_sq_reg     <= sq_next;
            s1_behind_reg <= behind_next;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_pa_reg     <= pa_next;
            s2_pb_reg     <= pb_next;
            s2_sq01_reg   <= SQ_W'(s1_sq_reg[0]) + SQ_W'(s1_sq_reg[1]);
            s2_sq2_reg    <= SQ_W'(s1_sq_reg[2]);
            s2_behind_reg <= s1_behind_reg;
        end
        if (s3_ready && s2_valid_reg)
        begin
            s3_n_reg      <= n_next;
            s3_status_reg <= s3_status_next;
        end
        if (s4_ready && s3_valid_reg)
        begin
            s4_mag_reg    <= mag_next;
            s4_sign_reg   <= {s3_n_reg[2][SUM_W-1], s3_n_reg[1][SUM_W-1],
                              s3_n_reg[0][SUM_W-1]};
            s4_status_reg <= s4_status_next;
        end
        if (s5_ready && s4_valid_reg)
            s5_word_reg   <= s5_word_next;
    end

    assign out_valid = s5_valid_reg;
    assign out_word  = s5_word_reg;

endmodule

// ----- rtl/lpip_div_cell.sv -----
module lpip_div_cell #(
    parameter int SHIFT = 0
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  lpip_pkg::div_t in_word,
    output logic           out_valid,
    input  logic           out_ready,
    output lpip_pkg::div_t out_word
);
    import lpip_pkg::*;

    logic           valid_reg;
    lpip_pkg::div_t word_reg, word_next;
    logic [REM_W-1:0] dsh;
    logic           take_u, take_v;

    assign in_ready = !valid_reg || out_ready;

    // Resolve one quotient bit for both columns and rows
    always_comb
    begin
        dsh       = REM_W'(in_word.dm) << SHIFT;
        take_u    = in_word.rem_u >= dsh;
        take_v    = in_word.rem_v >= dsh;
        word_next = in_word;
        word_next.rem_u = take_u ? in_word.rem_u - dsh : in_word.rem_u;
        word_next.rem_v = take_v ? in_word.rem_v - dsh : in_word.rem_v;
        word_next.q_u   = {in_word.q_u[PIXEL_WIDTH-2:0], take_u};
        word_next.q_v   = {in_word.q_v[PIXEL_WIDTH-2:0], take_v};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            word_reg <= word_next;
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

// ----- rtl/lidar_point_image_projection_top.sv -----
// The path from input to pixel output holds 18 register stages (5 front
// stages, one divider cell per quotient bit, 12 cells, and one
// output register). Throughput: one point per cycle; every stage holds its word
// under backpressure. The divider chain resolves one quotient bit per cell.
// Reset clears all valid bits, zeroes the matrix and sets width 1920, height 1208.
module lidar_point_image_projection_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [lpip_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [lpip_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 point_valid,
    output logic                                 point_ready,
    input  lpip_pkg::point_t                     point,
    output logic                                 pixel_valid,
    input  logic                                 pixel_ready,
    output lpip_pkg::pixel_t                     pixel
);
    import lpip_pkg::*;

    logic [CFG_DATA_W-1:0]  coef_reg [6];
    logic [PIXEL_WIDTH-1:0] width_reg, height_reg;
    lpip_pkg::matrix_t      coef;

    logic           chain_valid [PIXEL_WIDTH+1];
    logic           chain_ready [PIXEL_WIDTH+1];
    lpip_pkg::div_t chain_word  [PIXEL_WIDTH+1];

    logic             out_valid_reg;
    lpip_pkg::pixel_t out_reg, out_next;
    logic             out_ready;
    lpip_pkg::div_t   fin;
    logic             fail;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
                coef_reg[i] <= '0;
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ROW0_A: coef_reg[0] <= cfg_data;
                REG_ROW0_B: coef_reg[1] <= cfg_data;
                REG_ROW1_A: coef_reg[2] <= cfg_data;
                REG_ROW1_B: coef_reg[3] <= cfg_data;
                REG_ROW2_A: coef_reg[4] <= cfg_data;
                REG_ROW2_B: coef_reg[5] <= cfg_data;
                REG_WIDTH:  width_reg   <= cfg_data[PIXEL_WIDTH-1:0];
                REG_HEIGHT: height_reg  <= cfg_data[PIXEL_WIDTH-1:0];
                default:    ;
            endcase
        end
    end

    // Unpack the matrix
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            coef[r][0] = coef_reg[2*r][COEF_WIDTH-1:0];
            coef[r][1] = coef_reg[2*r][2*COEF_WIDTH-1:COEF_WIDTH];
            coef[r][2] = coef_reg[2*r+1][COEF_WIDTH-1:0];
            coef[r][3] = coef_reg[2*r+1][2*COEF_WIDTH-1:COEF_WIDTH];
        end
    end

    lpip_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (point_valid),
        .in_ready  (point_ready),
        .in_word   (point),
        .coef      (coef),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[0]),
        .out_word  (chain_word[0])
    );

    // Divider chain, most significant quotient bit first
    for (genvar k = 0; k < PIXEL_WIDTH; k++)
    begin : g_cell
        lpip_div_cell #(
            .SHIFT (PIXEL_WIDTH - 1 - k)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[k]),
            .in_ready  (chain_ready[k]),
            .in_word   (chain_word[k]),
            .out_valid (chain_valid[k+1]),
            .out_ready (chain_ready[k+1]),
            .out_word  (chain_word[k+1])
        );
    end

    // Check signs and image bounds
    always_comb
    begin
        fin  = chain_word[PIXEL_WIDTH];
        fail = (fin.q_u != '0 && fin.sign_u != fin.sign_d)
            || (fin.q_v != '0 && fin.sign_v != fin.sign_d)
            || (fin.q_u >= width_reg) || (fin.q_v >= height_reg);
        if (fin.status != ST_ON_IMAGE)
            out_next.status = fin.status;
        else if (fail)
            out_next.status = ST_OFF_IMAGE;
        else
            out_next.status = ST_ON_IMAGE;
        out_next.pixel_u = (out_next.status == ST_ON_IMAGE) ? fin.q_u : '0;
        out_next.pixel_v = (out_next.status == ST_ON_IMAGE) ? fin.q_v : '0;
    end

    assign out_ready = !out_valid_reg || pixel_ready;
    assign chain_ready[PIXEL_WIDTH] = out_ready;

    // Hold the result word until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_ready)
            out_valid_reg <= chain_valid[PIXEL_WIDTH];
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && chain_valid[PIXEL_WIDTH])
            out_reg <= out_next;
    end

    assign pixel_valid = out_valid_reg;
    assign pixel       = out_reg;

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.status != ST_ON_IMAGE
        |-> out_reg.pixel_u == '0 && out_reg.pixel_v == '0)
        else $error("failed point carries a nonzero pixel");

    a_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.status == ST_ON_IMAGE
        |-> out_reg.pixel_u < width_reg && out_reg.pixel_v < height_reg)
        else $error("on-image pixel outside the configured bounds");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> point_ready)
        else $error("input stalled while the output register is empty");

endmodule
